// File: src/tplwb_pkg.sv
// tplwb_pkg: constants and tables for the tuner pll register word builder
// band table, low-pass table, write group and status codes
// no dependencies
package tplwb_pkg;

    localparam int BAND_COUNT = 9;
    localparam int LPF_COUNT  = 13;

    // frequency limits in 100 kHz units
    localparam logic [14:0] FREQ_MIN = 15'd9500;
    localparam logic [14:0] FREQ_MAX = 15'd21500;
    // at or below this the reference step is 500 kHz
    localparam logic [14:0] FREQ_REF = 15'd10240;

    // reciprocal of 5 (shift 18) and of 10 (shift 19), exact for 15-bit inputs
    localparam logic [15:0] RECIP_MUL = 16'd52429;
    localparam int          RECIP_SH5 = 18;
    localparam int          RECIP_SH10 = 19;

    localparam logic [31:0] SRATE_MUL = 32'd27;

    // exclusive upper band edges in 100 kHz units, lower edges are contiguous
    localparam logic [14:0] BAND_HI [BAND_COUNT] = '{
        15'd9860, 15'd10730, 15'd11540, 15'd12910, 15'd14470,
        15'd16150, 15'd17910, 15'd19720, 15'd21500
    };
    localparam logic BAND_PSC [BAND_COUNT] = '{
        1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1
    };
    localparam logic BAND_DIV [BAND_COUNT] = '{
        1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0
    };
    localparam logic [2:0] BAND_BA [BAND_COUNT] = '{
        3'd5, 3'd6, 3'd7, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6
    };

    // bw <= m  <=>  srate*27 < (m+1)*32000000, for m = 10, 12 ... 34
    localparam logic [31:0] LPF_LIMIT [LPF_COUNT] = '{
        32'd352000000, 32'd416000000, 32'd480000000, 32'd544000000,
        32'd608000000, 32'd672000000, 32'd736000000, 32'd800000000,
        32'd864000000, 32'd928000000, 32'd992000000, 32'd1056000000,
        32'd1120000000
    };
    localparam logic [3:0] LPF_CODE [LPF_COUNT] = '{
        4'hc, 4'h2, 4'ha, 4'h6, 4'he, 4'h1, 4'h9, 4'h5, 4'hd, 4'h3, 4'hb, 4'h7, 4'hf
    };

    // write groups
    localparam logic [1:0] GRP_MAIN   = 2'd0;
    localparam logic [1:0] GRP_TM     = 2'd1;
    localparam logic [1:0] GRP_FILTER = 2'd2;
    localparam logic [1:0] GRP_STATUS = 2'd3;

    // status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_RANGE   = 3'd1;
    localparam logic [2:0] ST_NO_BAND = 3'd2;
    localparam logic [2:0] ST_DIVIDER = 3'd3;
    localparam logic [2:0] ST_BW_WIDE = 3'd4;

    // configuration register indexes
    localparam logic CFG_BB_GAIN     = 1'b0;
    localparam logic CFG_CHARGE_PUMP = 1'b1;

    // reset values of the configuration registers
    localparam logic [1:0] BB_GAIN_RST     = 2'd2;
    localparam logic [1:0] CHARGE_PUMP_RST = 2'd3;

    // item counts per run
    localparam logic [2:0] CNT_FULL   = 3'd7;
    localparam logic [2:0] CNT_BW     = 3'd6;
    localparam logic [2:0] CNT_STATUS = 3'd1;

endpackage

// File: src/tuner_pll_register_word_builder_top.sv
// tuner pll register word builder: tune request in, synthesizer register words out
// the request passes the input, compute and result buffer registers before its first word shows
// words: 7 per request on success, 6 on bandwidth error, 1 on other errors;
//   the output serialiser sets the rate, one word per cycle while out_ready is high
// reset: rst_n async active low clears all valids, gain to 2 and charge pump to 3
// depends on tplwb_pkg
module tuner_pll_register_word_builder_top
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [1:0]  cfg_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [14:0] freq_100khz,
    input  logic [26:0] symbol_rate,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  reg_byte,
    output logic [1:0]  write_group,
    output logic        end_of_group,
    output logic        last,
    output logic [2:0]  status
);

    // configuration
    logic [1:0] bb_gain_reg;
    logic [1:0] charge_pump_reg;

    // input stage
    logic        s1_valid_reg;
    logic [14:0] s1_freq_reg;
    logic [26:0] s1_srate_reg;

    // compute stage
    logic        s2_valid_reg;
    logic [2:0]  s2_status_reg;
    logic        s2_ref_reg;
    logic        s2_psc_reg;
    logic        s2_div_reg;
    logic [2:0]  s2_ba_reg;
    logic [11:0] s2_word_reg;
    logic [31:0] s2_srate27_reg;

    // result buffer
    logic        s3_valid_reg;
    logic [2:0]  s3_count_reg;
    logic [2:0]  s3_status_reg;
    logic [2:0]  s3_idx_reg;
    logic [7:0]  s3_bytes_reg [0:6];

    logic s3_done, s3_load, s2_free, s1_free;
    logic s2_load, s1_load;

    assign s3_done = s3_valid_reg && out_ready && (s3_idx_reg == s3_count_reg - 3'd1);
    assign s3_load = !s3_valid_reg || s3_done;
    assign s2_load = s2_valid_reg && s3_load;
    assign s2_free = !s2_valid_reg || s3_load;
    assign s1_load = s1_valid_reg && s2_free;
    assign s1_free = !s1_valid_reg || s2_free;
    assign in_ready = s1_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bb_gain_reg     <= tplwb_pkg::BB_GAIN_RST;
            charge_pump_reg <= tplwb_pkg::CHARGE_PUMP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tplwb_pkg::CFG_BB_GAIN:     bb_gain_reg     <= cfg_data;
                tplwb_pkg::CFG_CHARGE_PUMP: charge_pump_reg <= cfg_data;
                default:                    bb_gain_reg     <= bb_gain_reg;
            endcase
        end
    end

    // ---------------- input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_free)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_freq_reg  <= freq_100khz;
            s1_srate_reg <= symbol_rate;
        end
    end

    // ---------------- range check, band lookup, divider word
    logic [2:0]  s2_status_next;
    logic        s2_ref_next;
    logic [3:0]  band_idx;
    logic        band_ok;
    logic [30:0] recip_prod;
    logic [11:0] s2_word_next;
    logic [31:0] s2_srate27_next;

    always_comb
    begin
        band_idx = 4'd0;
        band_ok  = 1'b0;
        // edges are contiguous, so the first upper edge above freq picks the band
        for (int i = tplwb_pkg::BAND_COUNT - 1; i >= 0; i--)
        begin
            if (s1_freq_reg < tplwb_pkg::BAND_HI[i])
            begin
                band_idx = 4'(i);
                band_ok  = 1'b1;
            end
        end

        priority if (s1_freq_reg < tplwb_pkg::FREQ_MIN || s1_freq_reg > tplwb_pkg::FREQ_MAX)
            s2_status_next = tplwb_pkg::ST_RANGE;
        else if (!band_ok)
            s2_status_next = tplwb_pkg::ST_NO_BAND;
        else
            s2_status_next = tplwb_pkg::ST_OK;

        s2_ref_next = (s1_freq_reg <= tplwb_pkg::FREQ_REF);

        // kHz/500 = freq/5, kHz/1000 = freq/10
        recip_prod = 31'({16'd0, s1_freq_reg} * {15'd0, tplwb_pkg::RECIP_MUL});
        if (s2_ref_next)
            s2_word_next = 12'(recip_prod >> tplwb_pkg::RECIP_SH5);
        else
            s2_word_next = 12'(recip_prod >> tplwb_pkg::RECIP_SH10);

        s2_srate27_next = {5'd0, s1_srate_reg} * tplwb_pkg::SRATE_MUL;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s2_free)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s2_status_reg  <= s2_status_next;
            s2_ref_reg     <= s2_ref_next;
            s2_psc_reg     <= tplwb_pkg::BAND_PSC[band_idx];
            s2_div_reg     <= tplwb_pkg::BAND_DIV[band_idx];
            s2_ba_reg      <= tplwb_pkg::BAND_BA[band_idx];
            s2_word_reg    <= s2_word_next;
            s2_srate27_reg <= s2_srate27_next;
        end
    end

    // ---------------- N/A split, limits, low-pass pick, word build
    logic [7:0] div_n;
    logic [4:0] div_a;
    logic       div_bad;
    logic [3:0] lpf_code;
    logic       lpf_ok;
    logic [7:0] b2, b3, b4, b5, b4tm;
    logic [2:0] s3_count_next;
    logic [2:0] s3_status_next;

    always_comb
    begin
        if (s2_psc_reg)
        begin
            div_n = s2_word_reg[11:4];
            div_a = {1'b0, s2_word_reg[3:0]};
        end
        else
        begin
            div_n = {1'b0, s2_word_reg[11:5]};
            div_a = s2_word_reg[4:0];
        end
        // n above 255 and a above 31 cannot occur at these widths
        div_bad = ({3'd0, div_a} > div_n) || (div_n < 8'd5);

        lpf_code = 4'd0;
        lpf_ok   = 1'b0;
        for (int i = tplwb_pkg::LPF_COUNT - 1; i >= 0; i--)
        begin
            if (s2_srate27_reg < tplwb_pkg::LPF_LIMIT[i])
            begin
                lpf_code = tplwb_pkg::LPF_CODE[i];
                lpf_ok   = 1'b1;
            end
        end

        b2   = {1'b0, bb_gain_reg, div_n[7:3]};
        b3   = {div_n[2:0], div_a};
        b4   = {1'b1, charge_pump_reg, 4'b0000, s2_ref_reg};
        b5   = {s2_ba_reg, s2_psc_reg, 2'b00, s2_div_reg, 1'b1};
        b4tm = b4 | 8'h04;

        priority if (s2_status_reg != tplwb_pkg::ST_OK)
        begin
            s3_count_next  = tplwb_pkg::CNT_STATUS;
            s3_status_next = s2_status_reg;
        end
        else if (div_bad)
        begin
            s3_count_next  = tplwb_pkg::CNT_STATUS;
            s3_status_next = tplwb_pkg::ST_DIVIDER;
        end
        else if (!lpf_ok)
        begin
            s3_count_next  = tplwb_pkg::CNT_BW;
            s3_status_next = tplwb_pkg::ST_BW_WIDE;
        end
        else
        begin
            s3_count_next  = tplwb_pkg::CNT_FULL;
            s3_status_next = tplwb_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s3_idx_reg   <= 3'd0;
        end
        else if (s3_load)
        begin
            s3_valid_reg <= s2_valid_reg;
            s3_idx_reg   <= 3'd0;
        end
        else if (out_ready)
            s3_idx_reg <= s3_idx_reg + 3'd1;
    end

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            s3_count_reg    <= s3_count_next;
            s3_status_reg   <= s3_status_next;
            s3_bytes_reg[0] <= b2;
            s3_bytes_reg[1] <= b3;
            s3_bytes_reg[2] <= b4;
            s3_bytes_reg[3] <= b5;
            s3_bytes_reg[4] <= b4tm;
            s3_bytes_reg[5] <= b4tm | {3'b000, lpf_code[3:2], 3'b000};
            s3_bytes_reg[6] <= b5 | {4'b0000, lpf_code[1:0], 2'b00};
        end
    end

    // ---------------- output word select
    logic is_final;

    assign is_final  = (s3_idx_reg == s3_count_reg - 3'd1);
    assign out_valid = s3_valid_reg;

    always_comb
    begin
        if (is_final && s3_status_reg != tplwb_pkg::ST_OK)
        begin
            reg_byte     = 8'd0;
            write_group  = tplwb_pkg::GRP_STATUS;
            end_of_group = 1'b1;
            last         = 1'b1;
            status       = s3_status_reg;
        end
        else
        begin
            reg_byte = s3_bytes_reg[s3_idx_reg];
            unique case (s3_idx_reg)
                3'd4:       write_group = tplwb_pkg::GRP_TM;
                3'd5, 3'd6: write_group = tplwb_pkg::GRP_FILTER;
                default:    write_group = tplwb_pkg::GRP_MAIN;
            endcase
            end_of_group = (s3_idx_reg == 3'd3) || (s3_idx_reg == 3'd4) ||
                           (s3_idx_reg == 3'd6);
            last         = is_final;
            status       = tplwb_pkg::ST_OK;
        end
    end

endmodule

// File: src/tplwb_checker.sv
// tplwb_checker: port-level checks on the tuner pll register word builder output
// bound to tuner_pll_register_word_builder_top; depends on tplwb_pkg
module tplwb_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] reg_byte,
    input logic [1:0] write_group,
    input logic       end_of_group,
    input logic       last,
    input logic [2:0] status
);

    // a stalled word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(reg_byte) && $stable(write_group))
        else $error("stalled output word changed");

    // an error word ends the run on its own
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != tplwb_pkg::ST_OK |->
            last && end_of_group && write_group == tplwb_pkg::GRP_STATUS && reg_byte == 8'd0)
        else $error("malformed status word");

    // a successful run ends with the filter write
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last && status == tplwb_pkg::ST_OK |->
            write_group == tplwb_pkg::GRP_FILTER && end_of_group)
        else $error("successful run did not end on the filter write");

    // the tm resend is a single word and is followed by the filter write or an error
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && write_group == tplwb_pkg::GRP_TM |->
            end_of_group && !last ##1 (!out_valid || write_group == tplwb_pkg::GRP_FILTER ||
                                       write_group == tplwb_pkg::GRP_STATUS))
        else $error("bad sequence around tm resend");

endmodule

bind tuner_pll_register_word_builder_top tplwb_checker u_tplwb_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .reg_byte     (reg_byte),
    .write_group  (write_group),
    .end_of_group (end_of_group),
    .last         (last),
    .status       (status)
);
